// File: src/aid_pkg.sv
`timescale 1ns / 1ps
package aid_pkg;

  // default sizing of the descriptor table
  localparam int unsigned TableEntriesDef    = 64;
  localparam int unsigned MaxRankDef         = 8;
  localparam int unsigned DefaultBoundDef    = 10;
  localparam int unsigned ElementCapacityDef = 65536;

  // request codes
  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_DIM    = 2'd1,
    REQ_ERASE  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SUB  = 3'd1,
    ST_DUP      = 3'd2,
    ST_NO_MEM   = 3'd3,
    ST_NOT_FND  = 3'd4,
    ST_RSVD5    = 3'd5,
    ST_RSVD6    = 3'd6,
    ST_RSVD7    = 3'd7
  } status_e;

endpackage

// File: src/aid_ram.sv
`timescale 1ns / 1ps
module aid_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/array_descriptor_index_unit.sv
`timescale 1ns / 1ps
// Array descriptor index unit. Holds up to TABLE_ENTRIES array descriptors (name, kind, rank,
// bounds) in two RAMs and resolves access, dimension, erase and clear requests one word at a
// time. A subscript or bound word that is not last is stored while the unit stays idle. A
// final word starts a search of the table entries (meta RAM read then compare per entry),
// then a walk through the shared multiplier for each dimension (bound read, offset
// multiply-add, total multiply), with decode before the walk and commit and output after it;
// an erase then moves the last entry into the freed slot. A clear goes straight to output.
// Input ready is low while a request is in progress and while a result word waits on the output.
module array_descriptor_index_unit #(
  parameter int unsigned TABLE_ENTRIES    = aid_pkg::TableEntriesDef,
  parameter int unsigned MAX_RANK         = aid_pkg::MaxRankDef,
  parameter int unsigned DEFAULT_BOUND    = aid_pkg::DefaultBoundDef,
  parameter int unsigned ELEMENT_CAPACITY = aid_pkg::ElementCapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               index_base_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         name_first_i,
  input  logic [7:0]         name_second_i,
  input  logic [1:0]         value_kind_i,
  input  logic signed [15:0] number_in_i,
  input  logic               last_number_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         slot_o,
  output logic [15:0]        element_offset_o,
  output logic [16:0]        element_total_o,
  output logic               created_o,
  output logic [2:0]         status_o
);
  import aid_pkg::*;

  localparam int unsigned SL_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SLX_W = (SL_W > 6) ? SL_W : 6;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RK_W  = $clog2(MAX_RANK + 1);
  localparam int unsigned RK_IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned PC_W  = $clog2(MAX_RANK + 2);
  localparam int unsigned BDEP  = TABLE_ENTRIES * MAX_RANK;
  localparam int unsigned BA_W  = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int unsigned TC_W  = $clog2(ELEMENT_CAPACITY + 2);
  localparam int unsigned T_W   = (TC_W > 17) ? TC_W : 17;
  localparam int unsigned MW    = 18 + RK_W;
  localparam int unsigned P_W   = T_W + 16;

  localparam logic [T_W-1:0]   CapT   = T_W'(ELEMENT_CAPACITY);
  localparam logic [T_W-1:0]   CapP1  = T_W'(ELEMENT_CAPACITY + 1);
  localparam logic [15:0]      DefB   = 16'(DEFAULT_BOUND);
  localparam logic [CNT_W-1:0] TabN   = CNT_W'(TABLE_ENTRIES);
  localparam logic [PC_W-1:0]  RankN  = PC_W'(MAX_RANK);
  localparam logic [RK_IW-1:0] RankL  = RK_IW'(MAX_RANK - 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SRD  = 11'b000_0000_0010,
    S_SCMP = 11'b000_0000_0100,
    S_DEC  = 11'b000_0000_1000,
    S_WRD  = 11'b000_0001_0000,
    S_WOFF = 11'b000_0010_0000,
    S_WTOT = 11'b000_0100_0000,
    S_FIN  = 11'b000_1000_0000,
    S_CMRD = 11'b001_0000_0000,
    S_CBRD = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    SRC_RAM  = 2'd0,
    SRC_PEND = 2'd1,
    SRC_DEF  = 2'd2
  } src_e;

  // bounds RAM address of one dimension of one slot
  function automatic logic [BA_W-1:0] baddr(input logic [SL_W-1:0] s, input logic [RK_IW-1:0] d);
    baddr = BA_W'(s) * BA_W'(MAX_RANK) + BA_W'(d);
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PC_W-1:0]   pc_q, pc_d, pc_nx;
  logic              base_q;
  logic [15:0]       pend_q [MAX_RANK];
  logic [15:0]       pend_d [MAX_RANK];
  req_e              req_q, req_d;
  logic [15:0]       name_q, name_d;
  logic [1:0]        kind_q, kind_d;
  logic [RK_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic              found_q, found_d;
  logic [SL_W-1:0]   idx_q, idx_d;
  logic [RK_W-1:0]   rank_q, rank_d;
  src_e              src_q, src_d;
  logic [RK_W-1:0]   wrank_q, wrank_d;
  logic [SL_W-1:0]   wslot_q, wslot_d;
  logic              chk_q, chk_d, wr_q, wr_d;
  logic [RK_IW-1:0]  d_q, d_d;
  logic [T_W-1:0]    t_q, t_d, off_q, off_d;
  logic [15:0]       size_q, size_d;
  logic              zero_q, zero_d, bad_q, bad_d;
  logic [SL_W-1:0]   rslot_q, rslot_d;
  logic [15:0]       roff_q, roff_d;
  logic [16:0]       rtot_q, rtot_d;
  logic              rcre_q, rcre_d;
  status_e           rst_q, rst_d;

  // RAM ports
  logic              m_we, m_re, b_we, b_re;
  logic [SL_W-1:0]   m_waddr, m_raddr;
  logic [MW-1:0]     m_wdata, m_rdata;
  logic [BA_W-1:0]   b_waddr, b_raddr;
  logic [15:0]       b_wdata, b_rdata;

  // walk datapath
  logic [15:0]        bound_w;
  logic signed [17:0] size_w;
  logic signed [16:0] sub_w;
  logic [15:0]        mul_b;
  logic [P_W-1:0]     mul_p;
  logic [SL_W-1:0]    last_slot;
  logic               sub_ok;

  aid_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_meta (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .re_i(m_re), .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  aid_ram #(.WIDTH(16), .DEPTH(BDEP)) u_bounds (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .re_i(b_re), .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  assign last_slot = SL_W'(cnt_q - CNT_W'(1));

  // bound of the current dimension and its size / subscript relative to base
  always_comb begin
    case (src_q)
      SRC_RAM:  bound_w = b_rdata;
      SRC_PEND: bound_w = pend_q[d_q];
      default:  bound_w = DefB;
    endcase
  end
  assign size_w = $signed({{2{bound_w[15]}}, bound_w}) - $signed({17'b0, base_q})
                  + 18'sd1;
  assign sub_w  = $signed({pend_q[d_q][15], pend_q[d_q]}) - $signed({16'b0, base_q});

  // shared multiplier: offset term in S_WOFF, running total in S_WTOT
  assign mul_b = (state_q == S_WOFF) ? sub_w[15:0] : size_q;
  assign mul_p = P_W'(t_q) * P_W'(mul_b);

  assign sub_ok = chk_q && !bad_q;

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  pc_d = pc_q;  pend_d = pend_q;
    req_d = req_q;  name_d = name_q;  kind_d = kind_q;  n_d = n_q;
    i_d = i_q;  found_d = found_q;  idx_d = idx_q;  rank_d = rank_q;
    src_d = src_q;  wrank_d = wrank_q;  wslot_d = wslot_q;  chk_d = chk_q;  wr_d = wr_q;
    d_d = d_q;  t_d = t_q;  off_d = off_q;  size_d = size_q;  zero_d = zero_q;  bad_d = bad_q;
    rslot_d = rslot_q;  roff_d = roff_q;  rtot_d = rtot_q;  rcre_d = rcre_q;  rst_d = rst_q;
    pc_nx = pc_q;
    m_we = 1'b0;  m_waddr = wslot_q;  m_wdata = {name_q, kind_q, n_q};
    m_re = 1'b0;  m_raddr = i_q[SL_W-1:0];
    b_we = 1'b0;  b_waddr = baddr(wslot_q, d_q);  b_wdata = bound_w;
    b_re = 1'b0;  b_raddr = baddr(wslot_q, d_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = req_e'(req_type_i);
          name_d = {name_first_i, name_second_i};
          kind_d = value_kind_i;
          i_d = '0;  found_d = 1'b0;
          rslot_d = '0;  roff_d = '0;  rtot_d = '0;  rcre_d = 1'b0;  rst_d = ST_OK;
          case (req_e'(req_type_i))
            REQ_CLEAR: begin
              cnt_d = '0;  pc_d = '0;  state_d = S_OUT;
            end
            REQ_ERASE: begin
              pc_d = '0;
              state_d = (cnt_q == '0) ? S_DEC : S_SRD;
            end
            default: begin
              // collect one number; too many marks overflow
              if (pc_q < RankN) begin
                pend_d[pc_q[RK_IW-1:0]] = number_in_i;
                pc_nx = pc_q + PC_W'(1);
              end else begin
                pc_nx = RankN + PC_W'(1);
              end
              if (last_number_i) begin
                pc_d = '0;
                if (pc_nx > RankN) begin
                  rst_d = ST_BAD_SUB;  state_d = S_OUT;
                end else begin
                  n_d = RK_W'(pc_nx);
                  state_d = (cnt_q == '0) ? S_DEC : S_SRD;
                end
              end else begin
                pc_d = pc_nx;
              end
            end
          endcase
        end
      end
      // linear name search, one entry per meta RAM read and compare
      S_SRD: begin
        m_re = 1'b1;  m_raddr = i_q[SL_W-1:0];  state_d = S_SCMP;
      end
      S_SCMP: begin
        if (m_rdata[MW-1:RK_W] == {name_q, kind_q}) begin
          found_d = 1'b1;  idx_d = i_q[SL_W-1:0];  rank_d = m_rdata[RK_W-1:0];
          state_d = S_DEC;
        end else if (i_q + CNT_W'(1) == cnt_q) begin
          state_d = S_DEC;
        end else begin
          i_d = i_q + CNT_W'(1);  state_d = S_SRD;
        end
      end
      // choose the bound source for the dimension walk
      S_DEC: begin
        d_d = '0;  t_d = T_W'(1);  off_d = '0;  zero_d = 1'b0;  bad_d = 1'b0;
        wr_d = 1'b0;  chk_d = 1'b0;
        if (found_q) begin
          src_d = SRC_RAM;  wrank_d = rank_q;  wslot_d = idx_q;
          chk_d = (req_q == REQ_ACCESS) && (rank_q == n_q);
          state_d = S_WRD;
        end else if (req_q == REQ_ERASE) begin
          rst_d = ST_NOT_FND;  state_d = S_OUT;
        end else if (cnt_q >= TabN) begin
          rst_d = ST_NO_MEM;  state_d = S_OUT;
        end else begin
          src_d = (req_q == REQ_DIM) ? SRC_PEND : SRC_DEF;
          wrank_d = n_q;  wslot_d = SL_W'(cnt_q);  wr_d = 1'b1;
          chk_d = (req_q == REQ_ACCESS);
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        b_re = 1'b1;  state_d = S_WOFF;
      end
      // size and subscript check, offset multiply-add
      S_WOFF: begin
        if (size_w < 18'sd1) zero_d = 1'b1;
        if (chk_q) begin
          if (sub_w[16] || ($signed({sub_w[16], sub_w}) >= size_w)) begin
            bad_d = 1'b1;
          end else begin
            off_d = off_q + mul_p[T_W-1:0];
          end
        end
        size_d = size_w[15:0];
        state_d = S_WTOT;
      end
      // running total, saturated just above capacity
      S_WTOT: begin
        if (!zero_q) begin
          t_d = (mul_p > P_W'(CapT)) ? CapP1 : mul_p[T_W-1:0];
        end
        b_we = wr_q;
        if (RK_W'(d_q) + RK_W'(1) == wrank_q) begin
          state_d = S_FIN;
        end else begin
          d_d = d_q + RK_IW'(1);  state_d = S_WRD;
        end
      end
      S_FIN: begin
        state_d = S_OUT;
        if (found_q) begin
          rslot_d = idx_q;  rtot_d = t_q[16:0];
          case (req_q)
            REQ_ERASE: begin
              d_d = '0;  state_d = S_CMRD;
            end
            REQ_DIM: rst_d = ST_DUP;
            default: begin
              rst_d  = sub_ok ? ST_OK : ST_BAD_SUB;
              roff_d = sub_ok ? off_q[15:0] : 16'd0;
            end
          endcase
        end else if (zero_q) begin
          rst_d = ST_BAD_SUB;
        end else if (t_q > CapT) begin
          rst_d = ST_NO_MEM;
        end else begin
          // commit the new entry
          m_we = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
          rslot_d = wslot_q;  rtot_d = t_q[16:0];  rcre_d = 1'b1;
          if (req_q == REQ_ACCESS) begin
            rst_d  = sub_ok ? ST_OK : ST_BAD_SUB;
            roff_d = sub_ok ? off_q[15:0] : 16'd0;
          end
        end
      end
      // erase: move the last entry into the freed slot
      S_CMRD: begin
        m_re = 1'b1;  m_raddr = last_slot;
        b_re = 1'b1;  b_raddr = baddr(last_slot, d_q);
        if (d_q != '0) begin
          m_we = 1'b1;  m_waddr = idx_q;  m_wdata = m_rdata;
        end
        state_d = S_CBRD;
      end
      S_CBRD: begin
        b_we = 1'b1;  b_waddr = baddr(idx_q, d_q);  b_wdata = b_rdata;
        if (d_q == '0) begin
          m_we = 1'b1;  m_waddr = idx_q;  m_wdata = m_rdata;
        end
        if (d_q == RankL) begin
          cnt_d = cnt_q - CNT_W'(1);  state_d = S_OUT;
        end else begin
          d_d = d_q + RK_IW'(1);  state_d = S_CMRD;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pc_q    <= '0;
      base_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      if (cfg_valid_i && (cnt_q == '0)) base_q <= index_base_i;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    req_q   <= req_d;   name_q <= name_d;   kind_q <= kind_d;  n_q <= n_d;
    i_q     <= i_d;     found_q <= found_d; idx_q <= idx_d;    rank_q <= rank_d;
    src_q   <= src_d;   wrank_q <= wrank_d; wslot_q <= wslot_d;
    chk_q   <= chk_d;   wr_q <= wr_d;       d_q <= d_d;
    t_q     <= t_d;     off_q <= off_d;     size_q <= size_d;
    zero_q  <= zero_d;  bad_q <= bad_d;
    rslot_q <= rslot_d; roff_q <= roff_d;   rtot_q <= rtot_d;
    rcre_q  <= rcre_d;  rst_q <= rst_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign slot_o           = 6'(SLX_W'(rslot_q));
  assign element_offset_o = roff_q;
  assign element_total_o  = rtot_q;
  assign created_o        = rcre_q;
  assign status_o         = rst_q;

endmodule

// File: src/aid_checker.sv
`timescale 1ns / 1ps
module aid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [5:0]         slot_o,
  input logic [15:0]        element_offset_o,
  input logic [16:0]        element_total_o,
  input logic               created_o,
  input logic [2:0]         status_o
);
  import aid_pkg::*;

  // one request at a time: no new word while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o)
      && $stable(element_offset_o) && $stable(element_total_o)
      && $stable(created_o) && $stable(status_o))
    else $error("result word changed while stalled");

  // offset only on a good access
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> element_offset_o == 16'd0)
    else $error("offset on failed request");

  // a created entry is reported ok or with a bad subscript only
  a_cre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && created_o |-> (status_o == ST_OK) || (status_o == ST_BAD_SUB))
    else $error("created with bad status");

  // status codes in range
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_BAD_SUB)
      || (status_o == ST_DUP) || (status_o == ST_NO_MEM) || (status_o == ST_NOT_FND))
    else $error("status code out of range");

endmodule

bind array_descriptor_index_unit aid_checker u_aid_checker (.*);
